@@ rtl/core/csps_pkg.sv @@
// shared types and constants of the cascaded position/speed servo
package csps_pkg;

  localparam int IO_W          = 32;  // width of every request and result data field
  localparam int GAIN_W        = 31;  // width of every configuration register
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 3;
  localparam int SUM_W         = 64;  // loop sum: accumulator plus three saturated terms
  localparam int PROD_SAT_LOG2 = 61;  // each scaled product saturates at 2**61
  localparam int MAX_CHUNK_W   = 32;  // widest operand slice fed to the multiplier

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POS_KP        = 3'd0,
    REG_POS_KI        = 3'd1,
    REG_POS_KD        = 3'd2,
    REG_POS_OUT_LIMIT = 3'd3,
    REG_SPD_KP        = 3'd4,
    REG_SPD_KI        = 3'd5,
    REG_SPD_KD        = 3'd6,
    REG_SPD_OUT_LIMIT = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  typedef struct packed {
    logic                   func;
    logic signed [IO_W-1:0] reference;
    logic signed [IO_W-1:0] angle_feedback;
    logic signed [IO_W-1:0] speed_feedback;
  } request_t;

  typedef struct packed {
    logic signed [IO_W-1:0] drive_command;
    logic signed [IO_W-1:0] speed_target;
  } response_t;

  typedef struct packed {
    logic  load_in;
    logic  calc_err;
    logic  prep;
    logic  mul_start;
    logic  add_term;
    logic  update_loop;
    logic  publish;
    logic  pos_sel;
    term_t term;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic mul_done;
  } dp_status_t;

endpackage

@@ rtl/core/csps_req_if.sv @@
// request channel of the servo: valid/ready with the request payload
interface csps_req_if;
  logic               valid;
  logic               ready;
  csps_pkg::request_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/csps_rsp_if.sv @@
// result channel of the servo: valid/ready with the result payload
interface csps_rsp_if;
  logic                valid;
  logic                ready;
  csps_pkg::response_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/csps_mul.sv @@
// iterative magnitude-by-gain multiplier, one operand slice per cycle
module csps_mul #(
  parameter int MAG_W = 33
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [MAG_W-1:0]                    mag,
  input  logic [csps_pkg::GAIN_W-1:0]         gain,
  output logic                                done,
  output logic [MAG_W+csps_pkg::GAIN_W-1:0]   prod
);
  import csps_pkg::*;

  localparam int NCHUNK = (MAG_W + MAX_CHUNK_W - 1) / MAX_CHUNK_W;
  localparam int CW     = (MAG_W + NCHUNK - 1) / NCHUNK;
  localparam int PAD_W  = NCHUNK * CW;
  localparam int PP_W   = CW + GAIN_W;
  localparam int ACC_W  = PAD_W + GAIN_W;
  localparam int CNT_W  = $clog2(NCHUNK + 1);

  logic [PAD_W-1:0]  mag_sh;
  logic [GAIN_W-1:0] gain_r;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [PP_W-1:0]   partial;

  // most significant slice first, so the running sum shifts up each step
  assign partial = PP_W'(mag_sh[PAD_W-1 -: CW]) * PP_W'(gain_r);
  assign prod    = acc[MAG_W+GAIN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NCHUNK);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_sh <= PAD_W'(mag);
      gain_r <= gain;
      acc    <= '0;
    end else if (busy) begin
      mag_sh <= mag_sh << CW;
      acc    <= (acc << CW) + ACC_W'(partial);
    end
  end

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");

endmodule

@@ rtl/core/csps_ctrl.sv @@
// servo sequencer: steps the datapath through one or both loops and the result slot
module csps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output csps_pkg::dp_cmd_t    cmd,
  input  csps_pkg::dp_status_t status
);
  import csps_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_ERR     = 7'b0000010,
    ST_PREP    = 7'b0000100,
    ST_MUL     = 7'b0001000,
    ST_MWAIT   = 7'b0010000,
    ST_CLAMP   = 7'b0100000,
    ST_PUBLISH = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   second, second_next;
  term_t  term, term_next;
  logic   pos_sel;

  // position loop runs first in cascaded mode, then the speed loop
  assign pos_sel   = status.func && !second;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    second_next = second;
    term_next   = term;
    cmd         = '0;
    cmd.pos_sel = pos_sel;
    cmd.term    = term;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          second_next = 1'b0;
          state_next  = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        term_next  = TERM_P;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (status.mul_done) begin
          cmd.add_term = 1'b1;
          case (term)
            TERM_P: begin
              term_next  = TERM_I;
              state_next = ST_MUL;
            end
            TERM_I: begin
              term_next  = TERM_D;
              state_next = ST_MUL;
            end
            default: state_next = ST_CLAMP;
          endcase
        end
      end
      ST_CLAMP: begin
        cmd.update_loop = 1'b1;
        if (pos_sel) begin
          second_next = 1'b1;
          state_next  = ST_ERR;
        end else begin
          state_next = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      second    <= 1'b0;
      term      <= TERM_P;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
      term   <= term_next;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> state == ST_MWAIT)
    else $error("product returned outside the wait state");

  a_publish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> rsp_valid)
    else $error("published result not presented");

endmodule

@@ rtl/core/csps_dp.sv @@
// datapath of the servo: gains, loop state, error, terms, clamp and result register
module csps_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [csps_pkg::REG_IDX_W-1:0]    register_index,
  input  logic [csps_pkg::GAIN_W-1:0]       write_data,
  input  csps_pkg::dp_cmd_t                 cmd,
  output csps_pkg::dp_status_t              status,
  input  csps_pkg::request_t                req_data,
  output csps_pkg::response_t               rsp_data
);
  import csps_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int XW     = (DW > IO_W) ? DW : IO_W;
  localparam int LW     = (DW > GAIN_W) ? DW : GAIN_W;
  localparam int OPW    = DW + 2;
  localparam int MAG_W  = DW + 1;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int SHW    = PROD_W - FRAC_BITS;
  localparam int CMPW   = (SHW > SUM_W) ? SHW : SUM_W;

  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [CMPW-1:0]      PSAT = CMPW'(1) << PROD_SAT_LOG2;

  function automatic logic signed [DW-1:0] sat_in(input logic signed [IO_W-1:0] v);
    logic signed [XW-1:0] x;
    x = XW'(v);
    if (x > XW'(DMAX)) begin
      sat_in = DMAX;
    end else if (x < XW'(DMIN)) begin
      sat_in = DMIN;
    end else begin
      sat_in = DW'(x);
    end
  endfunction

  function automatic logic signed [IO_W-1:0] to_io(input logic signed [DW-1:0] v);
    logic signed [XW-1:0] x;
    x = XW'(v);
    to_io = x[IO_W-1:0];
  endfunction

  // configuration
  logic [GAIN_W-1:0] cfg [NUM_REGS];

  // latched request
  logic                 func_r;
  logic signed [DW-1:0] ref_r, ang_r, rpm_r;

  // loop state
  logic signed [DW-1:0] pos_err_last, pos_err_prev, pos_accum;
  logic signed [DW-1:0] spd_err_last, spd_err_prev, spd_accum;

  // working registers
  logic signed [DW-1:0]    err_r, lim_r, neg_lim_r;
  logic signed [OPW-1:0]   p_r, d_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    op_neg_r;

  // loop selection
  logic signed [DW-1:0] sel_ref, sel_fdb, sel_e1, sel_e2, sel_acc;
  logic [GAIN_W-1:0]    sel_kp, sel_ki, sel_kd, sel_limit, sel_gain;

  logic signed [DW:0]      diff;
  logic signed [DW-1:0]    err_sat;
  logic signed [OPW-1:0]   op, abs_op;
  logic                    mul_done;
  logic [PROD_W-1:0]       prod;
  logic [SHW-1:0]          shifted;
  logic [CMPW-1:0]         shifted_ext;
  logic [SUM_W-1:0]        term_mag;
  logic signed [DW-1:0]    clamped;
  logic                    lim_cap;

  assign status.func     = func_r;
  assign status.mul_done = mul_done;

  always_comb begin
    if (cmd.pos_sel) begin
      sel_ref   = ref_r;
      sel_fdb   = ang_r;
      sel_e1    = pos_err_last;
      sel_e2    = pos_err_prev;
      sel_acc   = pos_accum;
      sel_kp    = cfg[REG_POS_KP];
      sel_ki    = cfg[REG_POS_KI];
      sel_kd    = cfg[REG_POS_KD];
      sel_limit = cfg[REG_POS_OUT_LIMIT];
    end else begin
      // cascaded mode feeds the fresh position output as speed reference
      sel_ref   = func_r ? pos_accum : ref_r;
      sel_fdb   = rpm_r;
      sel_e1    = spd_err_last;
      sel_e2    = spd_err_prev;
      sel_acc   = spd_accum;
      sel_kp    = cfg[REG_SPD_KP];
      sel_ki    = cfg[REG_SPD_KI];
      sel_kd    = cfg[REG_SPD_KD];
      sel_limit = cfg[REG_SPD_OUT_LIMIT];
    end
  end

  // saturated error
  assign diff = (DW+1)'(sel_ref) - (DW+1)'(sel_fdb);
  always_comb begin
    if (diff > (DW+1)'(DMAX)) begin
      err_sat = DMAX;
    end else if (diff < (DW+1)'(DMIN)) begin
      err_sat = DMIN;
    end else begin
      err_sat = DW'(diff);
    end
  end

  assign lim_cap = LW'(sel_limit) > LW'($unsigned(DMAX));

  // operand and gain of the current term
  always_comb begin
    case (cmd.term)
      TERM_P: begin
        op       = p_r;
        sel_gain = sel_kp;
      end
      TERM_I: begin
        op       = OPW'(err_r);
        sel_gain = sel_ki;
      end
      TERM_D: begin
        op       = d_r;
        sel_gain = sel_kd;
      end
      default: begin
        op       = p_r;
        sel_gain = sel_kp;
      end
    endcase
  end
  assign abs_op = op[OPW-1] ? -op : op;

  csps_mul #(.MAG_W(MAG_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .mag   (abs_op[MAG_W-1:0]),
    .gain  (sel_gain),
    .done  (mul_done),
    .prod  (prod)
  );

  // scale down, truncate toward zero on the magnitude, saturate
  assign shifted     = prod[PROD_W-1:FRAC_BITS];
  assign shifted_ext = CMPW'(shifted);
  assign term_mag    = SUM_W'((shifted_ext > PSAT) ? PSAT : shifted_ext);

  always_comb begin
    if (sum_r > SUM_W'(lim_r)) begin
      clamped = lim_r;
    end else if (sum_r < SUM_W'(neg_lim_r)) begin
      clamped = neg_lim_r;
    end else begin
      clamped = DW'(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg[i] <= '0;
      end
    end else if (write_enable) begin
      cfg[register_index] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_err_last <= '0;
      pos_err_prev <= '0;
      pos_accum    <= '0;
      spd_err_last <= '0;
      spd_err_prev <= '0;
      spd_accum    <= '0;
    end else if (cmd.update_loop) begin
      if (cmd.pos_sel) begin
        pos_accum    <= clamped;
        pos_err_prev <= pos_err_last;
        pos_err_last <= err_r;
      end else begin
        spd_accum    <= clamped;
        spd_err_prev <= spd_err_last;
        spd_err_last <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= req_data.func;
      ref_r  <= sat_in(req_data.reference);
      ang_r  <= sat_in(req_data.angle_feedback);
      rpm_r  <= sat_in(req_data.speed_feedback);
    end
    if (cmd.calc_err) begin
      err_r <= err_sat;
      lim_r <= lim_cap ? DMAX : DW'(sel_limit);
      sum_r <= SUM_W'(sel_acc);
    end
    if (cmd.prep) begin
      p_r       <= OPW'(err_r) - OPW'(sel_e1);
      d_r       <= OPW'(err_r) - (OPW'(sel_e1) <<< 1) + OPW'(sel_e2);
      neg_lim_r <= -lim_r;
    end
    if (cmd.mul_start) begin
      op_neg_r <= op[OPW-1];
    end
    if (cmd.add_term) begin
      sum_r <= op_neg_r ? sum_r - $signed(term_mag) : sum_r + $signed(term_mag);
    end
    if (cmd.publish) begin
      rsp_data.drive_command <= to_io(spd_accum);
      rsp_data.speed_target  <= to_io(pos_accum);
    end
  end

endmodule

@@ rtl/core/cascaded_position_speed_servo_unit.sv @@
// top level of the cascaded position/speed servo
//
// Two incremental PID loops in signed fixed point (DATA_WIDTH bits, FRAC_BITS
// fraction bits). Each request with func set runs the position loop on
// reference minus angle_feedback, clamps it to pos_out_limit and feeds that
// as the reference of the speed loop on speed_feedback; with func clear only
// the speed loop runs on reference, and the position state stays as it was.
// Each loop adds Kp*(e-e1) + Ki*e + Kd*(e-2*e1+e2) to its output and clamps
// it to plus or minus its limit (a zero limit forces zero). Requests are
// saturated into the DATA_WIDTH range; results are the low 32 bits of the
// loop outputs, and speed_target always shows the last position output.
// Timing: one request is worked on at a time. The three products of a loop
// go one after another through a single multiplier that takes one operand
// slice of at most 32 bits per cycle, NCHUNK = ceil((DATA_WIDTH+1)/32)
// slices. Each loop steps through its error, the operand preparation, three
// products each added to the sum, and the clamp; a request adds its load and
// the result slot. A finished result sits in an output register, so the next
// request is taken while it waits. Gain and limit writes go straight to
// their registers and belong between requests.
module cascaded_position_speed_servo_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  csps_req_if.sink                       request,
  csps_rsp_if.source                     response,
  input  logic                           write_enable,
  input  logic [csps_pkg::REG_IDX_W-1:0] register_index,
  input  logic [csps_pkg::GAIN_W-1:0]    write_data
);
  import csps_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer owns the handshakes and the result valid flag
  csps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath holds gains, loop state, the multiplier and the result payload
  csps_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .cmd            (cmd),
    .status         (status),
    .req_data       (request.data),
    .rsp_data       (response.data)
  );

endmodule
